@@ sv/scancode_to_ascii_line_buffer_defines.svh @@
// assertion macros for the scancode to ascii line buffer
`ifndef SCANCODE_TO_ASCII_LINE_BUFFER_DEFINES_SVH
`define SCANCODE_TO_ASCII_LINE_BUFFER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SCLB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define SCLB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/sclb_pkg.sv @@
// shared types, constants and key tables for the scancode line buffer
package sclb_pkg;

	// line buffer geometry
	localparam int BUF_SIZE = 256;
	localparam int POS_W    = $clog2(BUF_SIZE);
	localparam int FILL_W   = 8;

	// decoupling queue geometry
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// scancode fields and special keys
	localparam logic [7:0] SC_RELEASE = 8'h80;
	localparam logic [6:0] KEY_MASK   = 7'h7F;
	localparam logic [6:0] KEY_LSHIFT = 7'h2A;
	localparam logic [6:0] KEY_RSHIFT = 7'h36;
	localparam logic [6:0] KEY_LAST   = 7'h39;
	localparam int         NKEYS      = 58;

	// control characters
	localparam logic [6:0] CH_NUL = 7'h00;
	localparam logic [6:0] CH_BS  = 7'h08;
	localparam logic [6:0] CH_NL  = 7'h0A;

	// us layout, unshifted
	localparam logic [6:0] PLAIN_MAP [NKEYS] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
		7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
		7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
		7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
		7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
	};

	// us layout, shifted
	localparam logic [6:0] SHIFT_MAP [NKEYS] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
		7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
		7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
		7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
		7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
	};

	// classified item handed from front to back
	typedef struct packed {
		logic [6:0] ch;
		logic       is_bs;
	} q_entry_t;

	// queue status seen by front and back
	typedef struct packed {
		logic not_full;
		logic not_empty;
	} q_stat_t;

endpackage

@@ sv/sclb_scan_if.sv @@
// scancode input channel
interface sclb_scan_if;
	logic       valid;
	logic       ready;
	logic [7:0] scancode;

	modport source (output valid, output scancode, input ready);
	modport sink (input valid, input scancode, output ready);
endinterface

@@ sv/sclb_echo_if.sv @@
// echo result channel
interface sclb_echo_if;
	logic       valid;
	logic       ready;
	logic [6:0] echo_char;
	logic [7:0] fill_level;
	logic       line_done;

	modport source (output valid, output echo_char, output fill_level, output line_done,
		input ready);
	modport sink (input valid, input echo_char, input fill_level, input line_done,
		output ready);
endinterface

@@ sv/sclb_front.sv @@
// front end: accepts scancodes, tracks shift, looks up and classifies characters
module sclb_front (
	input  logic               clk,
	input  logic               arst_n,
	sclb_scan_if.sink          scan,
	input  sclb_pkg::q_stat_t  q_stat,
	output logic               push,
	output sclb_pkg::q_entry_t push_entry
);
	import sclb_pkg::*;

	logic       shift_down_q;
	logic       accept;
	logic       released;
	logic [6:0] key;
	logic       is_shift;
	logic [6:0] ch;

	// take an item whenever the queue has room
	assign scan.ready = q_stat.not_full;
	assign accept     = scan.valid && scan.ready;

	// split the scancode
	assign released = (scan.scancode & SC_RELEASE) != 8'h00;
	assign key      = scan.scancode[6:0] & KEY_MASK;
	assign is_shift = (key == KEY_LSHIFT) || (key == KEY_RSHIFT);

	// table lookup, keys past the table give nothing
	always_comb begin
		ch = CH_NUL;
		if (key <= KEY_LAST) begin
			ch = shift_down_q ? SHIFT_MAP[key[5:0]] : PLAIN_MAP[key[5:0]];
		end
	end

	// classify and hand off
	assign push             = accept && !is_shift && !released && (ch != CH_NUL);
	assign push_entry.ch    = ch;
	assign push_entry.is_bs = (ch == CH_BS);

	// held shift flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_down_q <= 1'b0;
		end else if (accept && is_shift) begin
			shift_down_q <= !released;
		end
	end
endmodule

@@ sv/sclb_queue.sv @@
// short fifo between front and back
module sclb_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sclb_pkg::q_entry_t push_entry,
	input  logic               pop,
	output sclb_pkg::q_entry_t head,
	output sclb_pkg::q_stat_t  q_stat,
	output logic [sclb_pkg::QCNT_W-1:0] count
);
	import sclb_pkg::*;

	q_entry_t          slots_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head             = slots_q[rd_ptr_q];
	assign q_stat.not_full  = count_q != QCNT_W'(QDEPTH);
	assign q_stat.not_empty = count_q != '0;
	assign count            = count_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end
endmodule

@@ sv/sclb_back.sv @@
// back end: edits the line buffer and holds the echo result
module sclb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sclb_pkg::q_stat_t  q_stat,
	input  sclb_pkg::q_entry_t head,
	output logic               pop,
	sclb_echo_if.source        echo
);
	import sclb_pkg::*;

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(BUF_SIZE - 1);

	logic [6:0]       line_store_mem [BUF_SIZE];
	logic [POS_W-1:0] write_pos_q;
	logic             out_valid_q;
	logic [6:0]       echo_char_q;
	logic [7:0]       fill_level_q;
	logic             line_done_q;

	logic [POS_W-1:0]        base_pos;
	logic [POS_W-1:0]        pos_nxt;
	logic [POS_W-1:0]        wr_addr;
	logic [6:0]              wr_data;
	logic                    wr_en;
	logic [POS_W+FILL_W-1:0] pos_ext;

	// take the next item when the output register is free or being drained
	assign pop = q_stat.not_empty && (!out_valid_q || echo.ready);

	// buffer edit for the head item
	always_comb begin
		base_pos = (write_pos_q == POS_LAST) ? '0 : write_pos_q;
		pos_nxt  = write_pos_q;
		wr_addr  = base_pos;
		wr_data  = head.ch;
		wr_en    = 1'b0;
		if (head.is_bs) begin
			wr_data = CH_NUL;
			if (write_pos_q != '0) begin
				pos_nxt = write_pos_q - 1'b1;
				wr_addr = write_pos_q - 1'b1;
				wr_en   = pop;
			end
		end else begin
			pos_nxt = base_pos + 1'b1;
			wr_en   = pop;
		end
	end

	// low bits of the position, zero extended when the buffer is small
	assign pos_ext = {{FILL_W{1'b0}}, pos_nxt};

	// position and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				write_pos_q <= pos_nxt;
				out_valid_q <= 1'b1;
			end else if (echo.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			echo_char_q  <= head.ch;
			fill_level_q <= pos_ext[FILL_W-1:0];
			line_done_q  <= (head.ch == CH_NL);
		end
	end

	// line store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_store_mem[wr_addr] <= wr_data;
		end
	end

	assign echo.valid      = out_valid_q;
	assign echo.echo_char  = echo_char_q;
	assign echo.fill_level = fill_level_q;
	assign echo.line_done  = line_done_q;
endmodule

@@ sv/scancode_to_ascii_line_buffer.sv @@
// top level of the set-1 scancode to ascii line buffer
// Takes one raw set-1 scancode per item and gives at most one echo item for it.
// An item is accepted every cycle while the four-entry queue between the decode
// front end and the buffer back end has room. A full queue holds off the input for
// that cycle even when an entry leaves it in the same cycle. The back end retires
// one queued character per cycle whenever its output register is empty or being
// taken, so the sustained rate is one item per cycle. An accepted scancode's echo
// passes through a queue slot and then the output register before it is presented.
// Shift presses and releases, other releases, unknown keys and codes past 0x39
// give no result. The line store has no reset and no clearing pass; only the write
// position, echo valid flag, queue pointers and count and shift flag are cleared.
`include "scancode_to_ascii_line_buffer_defines.svh"

module scancode_to_ascii_line_buffer (
	input  logic        clk,
	input  logic        arst_n,
	sclb_scan_if.sink   scan,
	sclb_echo_if.source echo
);
	import sclb_pkg::*;

	logic              push;
	logic              pop;
	q_entry_t          push_entry;
	q_entry_t          head;
	q_stat_t           q_stat;
	logic [QCNT_W-1:0] q_count;
	logic              sc_fire;
	logic              sc_shift;
	logic              done_seen;

	// decode front end
	sclb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan       (scan),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	// decoupling queue
	sclb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat),
		.count      (q_count)
	);

	// buffer back end
	sclb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.head   (head),
		.pop    (pop),
		.echo   (echo)
	);

	// terms used by the checks
	assign sc_fire   = scan.valid && scan.ready;
	assign sc_shift  = (scan.scancode[6:0] == KEY_LSHIFT) || (scan.scancode[6:0] == KEY_RSHIFT);
	assign done_seen = echo.valid && echo.line_done;

	// checks
	`SCLB_ASSERT_NOW(a_shift_no_push, clk, arst_n, sc_fire && sc_shift, !push, "shift queued")
	`SCLB_ASSERT_NOW(a_pop_nonempty, clk, arst_n, pop, q_count != '0, "pop from empty queue")
	`SCLB_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, q_count <= QCNT_W'(QDEPTH), "queue overflow")
	`SCLB_ASSERT_NOW(a_done_is_nl, clk, arst_n, done_seen, echo.echo_char == CH_NL, "bad done")
endmodule

@@ tb/tb_top.sv @@
// testbench for the scancode to ascii line buffer: directed table, then random typing
module tb_top;

	// line capacity comes from the design package
	localparam int LINE_CAP = sclb_pkg::BUF_SIZE;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_TARGET = 1950;

	// scancode fields and keys used by the stimulus
	localparam logic [7:0] REL_BIT     = 8'h80;
	localparam logic [6:0] KEY_NONE    = 7'h00;
	localparam logic [6:0] KEY_ESC     = 7'h01;
	localparam logic [6:0] KEY_ONE     = 7'h02;
	localparam logic [6:0] KEY_BKSP    = 7'h0E;
	localparam logic [6:0] KEY_TAB     = 7'h0F;
	localparam logic [6:0] KEY_ENTER   = 7'h1C;
	localparam logic [6:0] KEY_CTRL    = 7'h1D;
	localparam logic [6:0] KEY_A       = 7'h1E;
	localparam logic [6:0] KEY_SHIFT_L = 7'h2A;
	localparam logic [6:0] KEY_SHIFT_R = 7'h36;
	localparam logic [6:0] KEY_STAR    = 7'h37;
	localparam logic [6:0] KEY_ALT     = 7'h38;
	localparam logic [6:0] KEY_SPACE   = 7'h39;
	localparam logic [6:0] KEY_TOP     = 7'h39;
	localparam logic [6:0] KEY_PAST    = 7'h3A;
	localparam logic [6:0] KEY_MAX     = 7'h7F;

	// characters with special handling
	localparam logic [6:0] ASC_NUL = 7'h00;
	localparam logic [6:0] ASC_BS  = 7'h08;
	localparam logic [6:0] ASC_LF  = 7'h0A;
	localparam logic [6:0] ASC_ONE = 7'h31;
	localparam logic [6:0] ASC_BANG = 7'h21;

	// us layout, keys 0x00..0x39, unshifted and shifted
	localparam logic [6:0] PLAIN_KEYS [0:57] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
		7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
		7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
		7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
		7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
	};
	localparam logic [6:0] SHIFTED_KEYS [0:57] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
		7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
		7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
		7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
		7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
	};

	typedef struct packed {
		logic [6:0] ch;
		logic [7:0] fill;
		logic       done;
	} echo_item_t;

	// how a table row is checked
	typedef enum logic [1:0] {BY_MODEL, NO_ECHO, TYPED} check_t;

	typedef struct {
		logic [7:0] code;
		check_t     how;
		echo_item_t want;
	} key_row_t;

	logic clk = 1'b0;
	logic arst_n;

	sclb_scan_if scan_ch ();
	sclb_echo_if echo_ch ();

	scancode_to_ascii_line_buffer dut (
		.clk(clk),
		.arst_n(arst_n),
		.scan(scan_ch),
		.echo(echo_ch)
	);

	// predictor state
	bit pred_shift;
	int line_pos;

	echo_item_t echo_expect [$];
	int err_count;
	int cycle_count;
	int sent_items;
	int sender_idle_pct;
	int stall_pct;
	key_row_t key_rows [$];

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// one line per mismatch
	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
		err_count++;
	endtask

	// decode one scancode and edit the line position
	task automatic decode_key(input logic [7:0] code, output bit produces,
		output echo_item_t res);
		logic [6:0] k;
		logic [6:0] c;
		k = code[6:0];
		produces = 1'b0;
		res = '0;
		if (k == KEY_SHIFT_L || k == KEY_SHIFT_R) begin
			pred_shift = !code[7];
		end else if (!code[7] && k <= KEY_TOP) begin
			c = pred_shift ? SHIFTED_KEYS[k] : PLAIN_KEYS[k];
			if (c != ASC_NUL) begin
				if (c == ASC_BS) begin
					if (line_pos != 0)
						line_pos--;
				end else begin
					if (line_pos >= LINE_CAP - 1)
						line_pos = 0;
					line_pos++;
				end
				produces = 1'b1;
				res.ch = c;
				res.fill = line_pos[7:0];
				res.done = (c == ASC_LF);
			end
		end
	endtask

	// drive one scancode item, wait for acceptance, record what it should echo
	task automatic send_code(input logic [7:0] code, input check_t how,
		input echo_item_t want);
		int gap;
		bit produces;
		echo_item_t res;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			scan_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		scan_ch.valid <= 1'b1;
		scan_ch.scancode <= code;
		@(posedge clk);
		while (!scan_ch.ready)
			@(posedge clk);
		decode_key(code, produces, res);
		sent_items++;
		if (how == BY_MODEL && produces)
			echo_expect.push_back(res);
		else if (how == TYPED)
			echo_expect.push_back(want);
		@(negedge clk);
	endtask

	task automatic key_event(input logic [6:0] k, input bit up);
		send_code({up, k}, BY_MODEL, '0);
	endtask

	// stop sending until every pending echo has come back
	task automatic drain_echoes();
		scan_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (echo_expect.size() != 0);
	endtask

	// one random burst of typing, mostly well-formed press and release pairs
	task automatic type_burst();
		int pick;
		int reps;
		logic [6:0] k;
		pick = $urandom_range(99);
		if (pick < 45) begin
			k = 7'($urandom_range(KEY_TOP));
			key_event(k, 1'b0);
			if ($urandom_range(3) != 0)
				key_event(k, 1'b1);
		end else if (pick < 55) begin
			reps = $urandom_range(1, 3);
			repeat (reps) begin
				key_event(KEY_BKSP, 1'b0);
				key_event(KEY_BKSP, 1'b1);
			end
		end else if (pick < 67) begin
			key_event($urandom_range(1) ? KEY_SHIFT_L : KEY_SHIFT_R, 1'b0);
			reps = $urandom_range(1, 4);
			repeat (reps) begin
				k = 7'($urandom_range(KEY_TOP));
				key_event(k, 1'b0);
				key_event(k, 1'b1);
			end
			if ($urandom_range(7) != 0)
				key_event($urandom_range(1) ? KEY_SHIFT_L : KEY_SHIFT_R, 1'b1);
		end else if (pick < 73) begin
			key_event(KEY_ENTER, 1'b0);
			key_event(KEY_ENTER, 1'b1);
		end else if (pick < 82) begin
			// held key auto-repeat
			k = 7'($urandom_range(KEY_TOP));
			reps = $urandom_range(2, 12);
			repeat (reps)
				key_event(k, 1'b0);
			key_event(k, 1'b1);
		end else begin
			reps = $urandom_range(1, 3);
			repeat (reps)
				send_code(8'($urandom_range(255)), BY_MODEL, '0);
		end
	endtask

	// receiver stalls
	always @(negedge clk) begin
		echo_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// compare each accepted echo item with the oldest expectation
	always @(posedge clk) begin
		echo_item_t exp_item;
		if (arst_n && echo_ch.valid && echo_ch.ready) begin
			if (echo_expect.size() == 0) begin
				report_mismatch("echo with nothing pending", int'(echo_ch.echo_char), 0);
			end else begin
				exp_item = echo_expect.pop_front();
				if (echo_ch.echo_char !== exp_item.ch)
					report_mismatch("echo_char", int'(echo_ch.echo_char),
						int'(exp_item.ch));
				if (echo_ch.fill_level !== exp_item.fill)
					report_mismatch("fill_level", int'(echo_ch.fill_level),
						int'(exp_item.fill));
				if (echo_ch.line_done !== exp_item.done)
					report_mismatch("line_done", int'(echo_ch.line_done),
						int'(exp_item.done));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("scancode_to_ascii_line_buffer regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		scan_ch.valid = 1'b0;
		scan_ch.scancode = '0;
		echo_ch.ready = 1'b0;
		pred_shift = 1'b0;
		line_pos = 0;
		err_count = 0;
		cycle_count = 0;
		sent_items = 0;
		sender_idle_pct = 0;
		stall_pct = 0;

		// directed rows: edges of the decode and the line edits
		key_rows.push_back('{{1'b0, KEY_BKSP}, TYPED, '{ASC_BS, 8'd0, 1'b0}});
		key_rows.push_back('{REL_BIT | KEY_BKSP, NO_ECHO, '0});
		key_rows.push_back('{{1'b0, KEY_NONE}, NO_ECHO, '0});
		key_rows.push_back('{{1'b0, KEY_PAST}, NO_ECHO, '0});
		key_rows.push_back('{{1'b0, KEY_MAX}, NO_ECHO, '0});
		key_rows.push_back('{REL_BIT | KEY_MAX, NO_ECHO, '0});
		key_rows.push_back('{{1'b0, KEY_ONE}, TYPED, '{ASC_ONE, 8'd1, 1'b0}});
		key_rows.push_back('{{1'b0, KEY_ENTER}, TYPED, '{ASC_LF, 8'd2, 1'b1}});
		key_rows.push_back('{{1'b0, KEY_SHIFT_L}, NO_ECHO, '0});
		key_rows.push_back('{{1'b0, KEY_ONE}, TYPED, '{ASC_BANG, 8'd3, 1'b0}});
		key_rows.push_back('{{1'b0, KEY_A}, BY_MODEL, '0});
		key_rows.push_back('{REL_BIT | KEY_SHIFT_L, NO_ECHO, '0});
		key_rows.push_back('{{1'b0, KEY_SHIFT_R}, NO_ECHO, '0});
		key_rows.push_back('{{1'b0, KEY_ENTER}, BY_MODEL, '0});
		key_rows.push_back('{{1'b0, KEY_BKSP}, TYPED, '{ASC_BS, 8'd4, 1'b0}});
		key_rows.push_back('{REL_BIT | KEY_SHIFT_R, NO_ECHO, '0});
		key_rows.push_back('{{1'b0, KEY_SPACE}, BY_MODEL, '0});
		key_rows.push_back('{{1'b0, KEY_ESC}, BY_MODEL, '0});
		key_rows.push_back('{{1'b0, KEY_TAB}, BY_MODEL, '0});
		key_rows.push_back('{{1'b0, KEY_CTRL}, NO_ECHO, '0});
		key_rows.push_back('{{1'b0, KEY_ALT}, NO_ECHO, '0});
		key_rows.push_back('{{1'b0, KEY_STAR}, BY_MODEL, '0});
		key_rows.push_back('{REL_BIT | KEY_SPACE, NO_ECHO, '0});
		key_rows.push_back('{{1'b0, KEY_A}, BY_MODEL, '0});

		// hold reset, then release it
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (key_rows[i])
			send_code(key_rows[i].code, key_rows[i].how, key_rows[i].want);
		drain_echoes();

		// random typing in idling phases, draining between them
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					sender_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 81;
					stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					stall_pct = 81;
				end
				default: begin
					sender_idle_pct = 30;
					stall_pct = 30;
				end
			endcase
			while (sent_items < (ph + 1) * (ITEM_TARGET / 4))
				type_burst();
			drain_echoes();
		end

		// settle for the pipeline latency
		repeat (10) @(posedge clk);
		if (err_count == 0 && echo_expect.size() == 0)
			$display("scancode_to_ascii_line_buffer regression: pass");
		else
			$display("scancode_to_ascii_line_buffer regression: fail");
		$finish;
	end

endmodule
